// ===== src/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// shared status codes and status type for the quadratic root solver
// ----------------------------------------------------------------------------
package qrs_pkg;

   typedef logic [1:0] status_type;

   localparam status_type STAT_NOT_QUAD = 2'd0;
   localparam status_type STAT_NO_REAL  = 2'd1;
   localparam status_type STAT_DOUBLE   = 2'd2;
   localparam status_type STAT_TWO      = 2'd3;

endpackage

// ===== src/qrs_sqrt.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt
// pipelined floored integer square root, one root bit per register stage
// ----------------------------------------------------------------------------
module qrs_sqrt #(
   parameter int ROOT_W = 17,
   parameter int SIDE_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [2*ROOT_W-1:0]   in_rad,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [ROOT_W-1:0]     out_root,
   output logic [SIDE_W-1:0]     out_side
);

   localparam int RADW = 2 * ROOT_W;
   localparam int REMW = ROOT_W + 3;

   logic              valid_ff [0:ROOT_W];
   logic [RADW-1:0]   rad_ff   [0:ROOT_W];
   logic [REMW-1:0]   rem_ff   [0:ROOT_W];
   logic [ROOT_W-1:0] root_ff  [0:ROOT_W];
   logic [SIDE_W-1:0] side_ff  [0:ROOT_W];

   assign valid_ff[0] = in_valid;
   assign rad_ff[0]   = in_rad;
   assign rem_ff[0]   = '0;
   assign root_ff[0]  = '0;
   assign side_ff[0]  = in_side;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [REMW-1:0]   rem_t;
      logic [REMW-1:0]   trial;
      logic              ge;
      logic [REMW-1:0]   rem_in;
      logic [ROOT_W-1:0] root_in;

      always_comb begin
         rem_t   = {rem_ff[k][REMW-3:0], rad_ff[k][RADW-1 -: 2]};
         trial   = {1'b0, root_ff[k], 2'b01};
         ge      = (rem_t >= trial);
         rem_in  = ge ? (rem_t - trial) : rem_t;
         root_in = {root_ff[k][ROOT_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k+1]  <= {rad_ff[k][RADW-3:0], 2'b00};
            rem_ff[k+1]  <= rem_in;
            root_ff[k+1] <= root_in;
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_side  = side_ff[ROOT_W];

endmodule

// ===== src/qrs_div.sv =====
// ----------------------------------------------------------------------------
// qrs_div
// pipelined unsigned restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module qrs_div #(
   parameter int NUM_W  = 34,
   parameter int DEN_W  = 17,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quot,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [0:NUM_W];
   logic [NUM_W-1:0]  work_ff  [0:NUM_W];
   logic [DEN_W-1:0]  rem_ff   [0:NUM_W];
   logic [DEN_W-1:0]  den_ff   [0:NUM_W];
   logic [SIDE_W-1:0] side_ff  [0:NUM_W];

   assign valid_ff[0] = in_valid;
   assign work_ff[0]  = in_num;
   assign rem_ff[0]   = '0;
   assign den_ff[0]   = in_den;
   assign side_ff[0]  = in_side;

   // work holds the remaining dividend bits on top and the quotient bits below
   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [DEN_W:0]   trial;
      logic             ge;
      logic [DEN_W:0]   diff;
      logic [DEN_W-1:0] rem_in;

      always_comb begin
         trial  = {rem_ff[k], work_ff[k][NUM_W-1]};
         ge     = (trial >= {1'b0, den_ff[k]});
         diff   = trial - {1'b0, den_ff[k]};
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            work_ff[k+1] <= {work_ff[k][NUM_W-2:0], ge};
            rem_ff[k+1]  <= rem_in;
            den_ff[k+1]  <= den_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = valid_ff[NUM_W];
   assign out_quot  = work_ff[NUM_W];
   assign out_side  = side_ff[NUM_W];

endmodule

// ===== src/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver
// real roots of a*x^2 + b*x + c for signed fixed-point coefficients
// ----------------------------------------------------------------------------
// The req_ channel carries one coefficient set a, b, c per transaction; the
// rsp_ channel returns one transaction per set with the status and both roots
// in signed fixed point with ROOT_WIDTH/2 fraction bits, truncated toward zero
// and saturated. Status: not quadratic, no real roots, double root, two roots.
// Unused root fields read zero.
// The pipeline has two stages for the products and the discriminant,
// COEF_WIDTH+1 stages of the square root, one stage for the numerators,
// COEF_WIDTH+2+ROOT_WIDTH/2 stages of the two parallel dividers and the
// output register.
// Throughput is one transaction per cycle while the pipeline is not held.
// When the receiver stalls, one finished result waits in the output register
// and the next in a skid register; once the skid register is full the whole
// pipeline holds and req_tready drops, so nothing is lost or repeated.
// Reset clears all valid bits; the block takes a transaction right after.
// ----------------------------------------------------------------------------
module quadratic_root_solver
   import qrs_pkg::*;
#(
   parameter int COEF_WIDTH = 16,
   parameter int ROOT_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // coef_a, coef_b, coef_c
   input  logic [((3*COEF_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // status, root_plus, root_minus
   output logic [((2*ROOT_WIDTH+2+7)/8)*8-1:0] rsp_tdata
);

   localparam int CW    = COEF_WIDTH;
   localparam int RF    = ROOT_WIDTH / 2;
   localparam int DENW  = CW + 1;
   localparam int SQW   = CW + 1;
   localparam int NUMW  = CW + 2;
   localparam int NW    = NUMW + RF;
   localparam int EW    = ((NW > ROOT_WIDTH) ? NW : ROOT_WIDTH) + 1;
   localparam int OUTW  = ((2*ROOT_WIDTH+2+7)/8)*8;
   localparam int SQSW  = 4 + CW + DENW;
   localparam logic [EW-1:0] HALF_E = EW'(1) << (ROOT_WIDTH - 1);

   logic en;

   // ---------------- stage 1: magnitudes and products
   logic [CW-1:0]   a_s, b_s, c_s;
   logic [CW-1:0]   am, bm, cm;
   logic            s1_valid_ff;
   logic [2*CW-1:0] s1_bb_ff, s1_acm_ff;
   logic [CW-1:0]   s1_bm_ff;
   logic [DENW-1:0] s1_den_ff;
   logic            s1_acneg_ff, s1_azero_ff, s1_negb_ff, s1_aneg_ff;

   always_comb begin
      a_s = req_tdata[CW-1:0];
      b_s = req_tdata[2*CW-1:CW];
      c_s = req_tdata[3*CW-1:2*CW];
      am  = a_s[CW-1] ? (~a_s + 1'b1) : a_s;
      bm  = b_s[CW-1] ? (~b_s + 1'b1) : b_s;
      cm  = c_s[CW-1] ? (~c_s + 1'b1) : c_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_bb_ff    <= bm * bm;
         s1_acm_ff   <= am * cm;
         s1_bm_ff    <= bm;
         s1_den_ff   <= {am, 1'b0};
         s1_acneg_ff <= a_s[CW-1] ^ c_s[CW-1];
         s1_azero_ff <= (a_s == '0);
         s1_negb_ff  <= !b_s[CW-1] && (b_s != '0);
         s1_aneg_ff  <= a_s[CW-1];
      end
   end

   // ---------------- stage 2: discriminant and status
   logic [2*CW+1:0] bb_e, ac4_e, dsum;
   logic [2*CW:0]   d_in;
   status_type      stat_in;
   logic            s2_valid_ff;
   logic [2*CW:0]   s2_d_ff;
   logic [SQSW-1:0] s2_side_ff;

   always_comb begin
      bb_e  = {2'b00, s1_bb_ff};
      ac4_e = {s1_acm_ff, 2'b00};
      dsum  = '0;
      stat_in = STAT_TWO;
      if (s1_acneg_ff || ac4_e == '0) begin
         dsum = bb_e + ac4_e;
      end else if (bb_e < ac4_e) begin
         stat_in = STAT_NO_REAL;
      end else begin
         dsum = bb_e - ac4_e;
      end
      d_in = dsum[2*CW:0];
      if (s1_azero_ff) begin
         stat_in = STAT_NOT_QUAD;
         d_in    = '0;
      end else if (stat_in == STAT_TWO && d_in == '0) begin
         stat_in = STAT_DOUBLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_d_ff    <= d_in;
         s2_side_ff <= {stat_in, s1_negb_ff, s1_aneg_ff, s1_bm_ff, s1_den_ff};
      end
   end

   // ---------------- square root
   logic            sq_valid;
   logic [SQW-1:0]  sq_root;
   logic [SQSW-1:0] sq_side;

   qrs_sqrt #(
      .ROOT_W (SQW),
      .SIDE_W (SQSW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s2_valid_ff),
      .in_rad    ({1'b0, s2_d_ff}),
      .in_side   (s2_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // ---------------- stage: numerators -b+s and -b-s
   status_type      sq_stat;
   logic            sq_negb, sq_aneg;
   logic [NUMW-1:0] bm_e, s_e, sum_e, bms_e, smb_e;
   logic [NUMW-1:0] nump_in, numm_in;
   logic            negp_in, negm_in;
   logic            s3_valid_ff;
   logic [NW-1:0]   s3_nump_ff, s3_numm_ff;
   logic [DENW-1:0] s3_den_ff;
   status_type      s3_stat_ff;
   logic            s3_negp_ff, s3_negm_ff;

   always_comb begin
      sq_stat = sq_side[SQSW-1 -: 2];
      sq_negb = sq_side[SQSW-3];
      sq_aneg = sq_side[SQSW-4];
      bm_e    = {2'b00, sq_side[DENW+CW-1:DENW]};
      s_e     = {1'b0, sq_root};
      sum_e   = bm_e + s_e;
      bms_e   = bm_e - s_e;
      smb_e   = s_e - bm_e;
      if (sq_negb) begin
         if (s_e >= bm_e) begin
            nump_in = smb_e;
            negp_in = 1'b0;
         end else begin
            nump_in = bms_e;
            negp_in = 1'b1;
         end
         numm_in = sum_e;
         negm_in = 1'b1;
      end else begin
         nump_in = sum_e;
         negp_in = 1'b0;
         if (bm_e >= s_e) begin
            numm_in = bms_e;
            negm_in = 1'b0;
         end else begin
            numm_in = smb_e;
            negm_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_nump_ff <= {nump_in, RF'(0)};
         s3_numm_ff <= {numm_in, RF'(0)};
         s3_den_ff  <= sq_side[DENW-1:0];
         s3_stat_ff <= sq_stat;
         s3_negp_ff <= negp_in ^ sq_aneg;
         s3_negm_ff <= negm_in ^ sq_aneg;
      end
   end

   // ---------------- dividers
   logic          dp_valid, dm_valid;
   logic [NW-1:0] dp_quot, dm_quot;
   logic [2:0]    dp_side;
   logic [0:0]    dm_side;

   qrs_div #(
      .NUM_W  (NW),
      .DEN_W  (DENW),
      .SIDE_W (3)
   ) u_div_plus (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_num    (s3_nump_ff),
      .in_den    (s3_den_ff),
      .in_side   ({s3_stat_ff, s3_negp_ff}),
      .out_valid (dp_valid),
      .out_quot  (dp_quot),
      .out_side  (dp_side)
   );

   qrs_div #(
      .NUM_W  (NW),
      .DEN_W  (DENW),
      .SIDE_W (1)
   ) u_div_minus (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_num    (s3_numm_ff),
      .in_den    (s3_den_ff),
      .in_side   (s3_negm_ff),
      .out_valid (dm_valid),
      .out_quot  (dm_quot),
      .out_side  (dm_side)
   );

   // ---------------- saturation and result packing
   status_type              fin_stat;
   logic [EW-1:0]           qp_e, qm_e, magp, magm;
   logic [ROOT_WIDTH-1:0]   rootp, rootm;
   logic [OUTW-1:0]         fin_data;

   always_comb begin
      fin_stat = dp_side[2:1];
      qp_e = EW'(dp_quot);
      qm_e = EW'(dm_quot);
      if (dp_side[0]) begin
         magp = (qp_e > HALF_E) ? HALF_E : qp_e;
      end else begin
         magp = (qp_e > HALF_E - 1'b1) ? HALF_E - 1'b1 : qp_e;
      end
      if (dm_side[0]) begin
         magm = (qm_e > HALF_E) ? HALF_E : qm_e;
      end else begin
         magm = (qm_e > HALF_E - 1'b1) ? HALF_E - 1'b1 : qm_e;
      end
      rootp = dp_side[0] ? (~magp[ROOT_WIDTH-1:0] + 1'b1) : magp[ROOT_WIDTH-1:0];
      rootm = dm_side[0] ? (~magm[ROOT_WIDTH-1:0] + 1'b1) : magm[ROOT_WIDTH-1:0];
      if (fin_stat == STAT_NOT_QUAD || fin_stat == STAT_NO_REAL) begin
         rootp = '0;
      end
      if (fin_stat != STAT_TWO) begin
         rootm = '0;
      end
      fin_data = OUTW'({rootm, rootp, fin_stat});
   end

   // ---------------- output register and skid
   logic            rsp_valid_ff, skid_valid_ff;
   logic [OUTW-1:0] rsp_data_ff, skid_data_ff;

   assign en         = !skid_valid_ff;
   assign req_tready = en;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_tready) begin
            rsp_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (dp_valid) begin
         if (rsp_valid_ff && !rsp_tready) begin
            skid_data_ff  <= fin_data;
            skid_valid_ff <= 1'b1;
         end else begin
            rsp_data_ff  <= fin_data;
            rsp_valid_ff <= 1'b1;
         end
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // ---------------- assertions
   a_skid_behind_rsp : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

   a_div_lockstep : assert property (@(posedge clock) disable iff (reset)
      dp_valid == dm_valid)
      else $error("root dividers out of step");

   a_unused_roots_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff[1:0] == STAT_NOT_QUAD ||
                       rsp_data_ff[1:0] == STAT_NO_REAL)
      |-> rsp_data_ff[2*ROOT_WIDTH+1:2] == '0)
      else $error("roots not zero without real roots");

   a_double_minus_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[1:0] == STAT_DOUBLE
      |-> rsp_data_ff[2*ROOT_WIDTH+1:ROOT_WIDTH+2] == '0)
      else $error("second root not zero for a double root");

endmodule
